>>> rtl/pointer_gesture_recognizer_core_assert.svh
// ----------------------------------------------------------------------------
// Pointer gesture recognizer assertion macros
// Concurrent assertion wrappers clocked on clk_i; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef POINTER_GESTURE_RECOGNIZER_CORE_ASSERT_SVH
`define POINTER_GESTURE_RECOGNIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define PGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define PGR_ASSERT(lbl, prop, msg)
`define PGR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types and constants of the pointer gesture recognizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgDragThreshold   = 2'd0;
  localparam logic [1:0] CfgLongPressMs     = 2'd1;
  localparam logic [1:0] CfgRotateJumpLimit = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [11:0] DragThresholdReset   = 12'd10;
  localparam logic [13:0] LongPressMsReset     = 14'd1000;
  localparam logic [14:0] RotateJumpLimitReset = 15'd90;

  // Item kinds.
  localparam logic OpPointer = 1'b0;
  localparam logic OpTick    = 1'b1;

  // Held time saturates at this value.
  localparam logic [13:0] HeldMax = 14'h3FFF;

  // Result queue geometry.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    GestNone   = 3'd0,
    GestTap    = 3'd1,
    GestLong   = 3'd2,
    GestDrag   = 3'd3,
    GestRotate = 3'd4
  } gesture_e;

  // One result item.
  typedef struct packed {
    gesture_e           gesture;
    logic signed [16:0] param_a;
    logic signed [16:0] param_b;
    logic               handled;
    logic               last;
  } result_t;

  // Results produced by one accepted item (one or two).
  typedef struct packed {
    logic       push;
    logic       two;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Configuration as seen by the gesture engine.
  typedef struct packed {
    logic [23:0] thr_sq;
    logic [13:0] long_ms;
    logic [14:0] jump_limit;
  } cfg_t;

endpackage

>>> rtl/pgr_cfg.sv
// ----------------------------------------------------------------------------
// pgr_cfg
// Configuration registers; the drag threshold is stored squared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgr_cfg (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [14:0]  cfg_wdata_i,
  output pgr_pkg::cfg_t cfg_o
);
  import pgr_pkg::*;

  logic [11:0] thr;
  logic [23:0] thr_sq_d, thr_sq_q;
  logic [13:0] long_ms_q;
  logic [14:0] jump_limit_q;

  // Square the threshold once at write time to keep it off the item path.
  assign thr      = cfg_wdata_i[11:0];
  assign thr_sq_d = {12'd0, thr} * {12'd0, thr};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_sq_q     <= 24'(DragThresholdReset * DragThresholdReset);
      long_ms_q    <= LongPressMsReset;
      jump_limit_q <= RotateJumpLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDragThreshold:   thr_sq_q     <= thr_sq_d;
        CfgLongPressMs:     long_ms_q    <= cfg_wdata_i[13:0];
        CfgRotateJumpLimit: jump_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.thr_sq     = thr_sq_q;
  assign cfg_o.long_ms    = long_ms_q;
  assign cfg_o.jump_limit = jump_limit_q;

endmodule

>>> rtl/pgr_engine.sv
// ----------------------------------------------------------------------------
// pgr_engine
// Gesture state and the single-pass decision logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgr_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               op_i,
  input  logic               left_button_i,
  input  logic               right_button_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [9:0]         elapsed_ms_i,
  input  pgr_pkg::cfg_t      cfg_i,
  output pgr_pkg::push_t     push_o
);
  import pgr_pkg::*;

  // Control state.
  logic        pressed_d, pressed_q;
  logic        dragging_d, dragging_q;
  logic        rotating_d, rotating_q;
  logic [13:0] held_d, held_q;

  // Stored coordinates.
  logic signed [15:0] org_x_d, org_x_q, org_y_d, org_y_q;
  logic signed [15:0] drg_x_d, drg_x_q, drg_y_d, drg_y_q;
  logic signed [15:0] rot_x_d, rot_x_q, rot_y_d, rot_y_q;

  // Datapath terms.
  logic signed [16:0] px, py;
  logic signed [16:0] ddx, ddy;
  logic signed [33:0] sq_x, sq_y;
  logic [33:0]        dist_sq;
  logic               beyond_thr;
  logic signed [16:0] rdx, rdy;
  logic [16:0]        rmag;
  logic [14:0]        held_sum;
  logic [13:0]        held_sat;
  logic               long_fire;

  result_t r_left, r_rot, r_none;
  logic    left_v, rot_v, handled, rec;

  assign px = {pos_x_i[15], pos_x_i};
  assign py = {pos_y_i[15], pos_y_i};

  // Squared distance from the press point against the squared threshold.
  assign ddx        = px - {org_x_q[15], org_x_q};
  assign ddy        = py - {org_y_q[15], org_y_q};
  assign sq_x       = 34'(ddx) * 34'(ddx);
  assign sq_y       = 34'(ddy) * 34'(ddy);
  assign dist_sq    = sq_x + sq_y;
  assign beyond_thr = dist_sq > {10'd0, cfg_i.thr_sq};

  // Rotate deltas and the magnitude of the x delta.
  assign rdx  = px - {rot_x_q[15], rot_x_q};
  assign rdy  = py - {rot_y_q[15], rot_y_q};
  assign rmag = rdx[16] ? 17'(-rdx) : rdx;

  // Saturating held time and the long tap decision.
  assign held_sum  = {1'b0, held_q} + {5'd0, elapsed_ms_i};
  assign held_sat  = (held_sum > {1'b0, HeldMax}) ? HeldMax : held_sum[13:0];
  assign long_fire = held_sat > cfg_i.long_ms;

  // Next state and the candidate results of this item.
  always_comb begin
    pressed_d  = pressed_q;
    dragging_d = dragging_q;
    rotating_d = rotating_q;
    held_d     = held_q;
    org_x_d    = org_x_q;
    org_y_d    = org_y_q;
    drg_x_d    = drg_x_q;
    drg_y_d    = drg_y_q;
    rot_x_d    = rot_x_q;
    rot_y_d    = rot_y_q;
    left_v     = 1'b0;
    rot_v      = 1'b0;
    rec        = 1'b0;
    handled    = 1'b0;
    r_left     = '0;
    r_rot      = '0;
    r_none     = '0;
    r_none.gesture = GestNone;

    if (op_i == OpTick) begin
      if (pressed_q && !dragging_q && !rotating_q) begin
        held_d = held_sat;
        if (long_fire) begin
          left_v         = 1'b1;
          r_left.gesture = GestLong;
          r_left.param_a = {org_x_q[15], org_x_q};
          r_left.param_b = {org_y_q[15], org_y_q};
          pressed_d      = 1'b0;
          dragging_d     = 1'b0;
          held_d         = '0;
        end
      end
    end else begin
      // Left button path.
      if (left_button_i && !pressed_q) begin
        org_x_d    = pos_x_i;
        org_y_d    = pos_y_i;
        dragging_d = 1'b0;
        pressed_d  = 1'b1;
        held_d     = '0;
      end else if (left_button_i) begin
        if (!dragging_q) begin
          if (beyond_thr) begin
            org_x_d    = pos_x_i;
            org_y_d    = pos_y_i;
            drg_x_d    = pos_x_i;
            drg_y_d    = pos_y_i;
            dragging_d = 1'b1;
            rec        = 1'b1;
          end
        end else begin
          left_v         = 1'b1;
          r_left.gesture = GestDrag;
          r_left.param_a = px - {drg_x_q[15], drg_x_q};
          r_left.param_b = py - {drg_y_q[15], drg_y_q};
          drg_x_d        = pos_x_i;
          drg_y_d        = pos_y_i;
        end
      end else if (pressed_q) begin
        if (!dragging_q) begin
          left_v         = 1'b1;
          r_left.gesture = GestTap;
          r_left.param_a = px;
          r_left.param_b = py;
          rec            = 1'b1;
        end
        pressed_d  = 1'b0;
        dragging_d = 1'b0;
      end

      // Right button path.
      if (right_button_i && !rotating_q) begin
        rot_x_d    = pos_x_i;
        rot_y_d    = pos_y_i;
        rotating_d = 1'b1;
        handled    = 1'b1;
      end else if (right_button_i) begin
        rot_v         = 1'b1;
        r_rot.gesture = GestRotate;
        r_rot.param_a = (rmag > {2'd0, cfg_i.jump_limit}) ? '0 : rdx;
        r_rot.param_b = rdy;
        rot_x_d       = pos_x_i;
        rot_y_d       = pos_y_i;
        handled       = 1'b1;
      end else if (rotating_q) begin
        rotating_d = 1'b0;
        handled    = 1'b0;
      end else begin
        handled = rec;
      end
    end
  end

  // Order the results: left path first, rotate last, a blank one if none.
  always_comb begin
    push_o.push       = accept_i;
    push_o.two        = left_v && rot_v;
    push_o.r0         = left_v ? r_left : (rot_v ? r_rot : r_none);
    push_o.r0.last    = !(left_v && rot_v);
    push_o.r0.handled = (left_v && rot_v) ? 1'b0 : handled;
    push_o.r1         = r_rot;
    push_o.r1.last    = 1'b1;
    push_o.r1.handled = handled;
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= 1'b0;
      dragging_q <= 1'b0;
      rotating_q <= 1'b0;
      held_q     <= '0;
    end else if (accept_i) begin
      pressed_q  <= pressed_d;
      dragging_q <= dragging_d;
      rotating_q <= rotating_d;
      held_q     <= held_d;
    end
  end

  // Coordinate registers; they are always written before being read.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      org_x_q <= org_x_d;
      org_y_q <= org_y_d;
      drg_x_q <= drg_x_d;
      drg_y_q <= drg_y_d;
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
    end
  end

endmodule

>>> rtl/pgr_outq.sv
// ----------------------------------------------------------------------------
// pgr_outq
// Result queue: takes one or two results per item, hands out one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgr_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pgr_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pgr_pkg::result_t head_o
);
  import pgr_pkg::*;

  `include "pointer_gesture_recognizer_core_assert.svh"

  result_t          entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [QCntW-1:0] count_d, count_q;
  logic             pop;
  logic [1:0]       n_push;

  assign pop       = (count_q != '0) && !out_stall_i;
  assign n_push    = push_i.push ? (push_i.two ? 2'd2 : 2'd1) : 2'd0;
  assign wr_ptr_nx = wr_ptr_q + QPtrW'(1);
  assign count_d   = count_q + QCntW'(n_push) - QCntW'(pop);

  // Room for a full item of two results.
  assign room_o      = count_q <= QCntW'(QDepth - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      entry_q[wr_ptr_q] <= push_i.r0;
      if (push_i.two) begin
        entry_q[wr_ptr_nx] <= push_i.r1;
      end
    end
  end

  `PGR_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= QCntW'(QDepth), "result queue count out of range")
  `PGR_ASSERT(a_no_overflow, push_i.push |-> count_q <= QCntW'(QDepth - 2), "push without room")
  `PGR_ASSERT(a_empty_ptrs, count_q == '0 |-> rd_ptr_q == wr_ptr_q, "empty queue pointers differ")
  `PGR_ASSERT(a_pair_order, push_i.push && push_i.two |=> count_q >= QCntW'(2), "second result lost")

endmodule

>>> rtl/pointer_gesture_recognizer_core.sv
// The results of an accepted item enter the result queue and are offered behind
// older results. One item per cycle while the input does not stall; the decision
// logic is a single pass per item. An item with two results hands them out as two
// transfers, and the input stalls while the four-entry result queue holds more
// than two results. Reset (rst_ni, asynchronous, active low) clears gesture state,
// held time, the result queue and restores the default configuration.
// ----------------------------------------------------------------------------
// pointer_gesture_recognizer_core
// Sorts pointer events and time ticks into tap, long tap, drag and rotate-zoom.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pointer_gesture_recognizer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_wdata_i,
  // Input items.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic               left_button_i,
  input  logic               right_button_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [9:0]         elapsed_ms_i,
  // Result items.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         gesture_o,
  output logic signed [16:0] param_a_o,
  output logic signed [16:0] param_b_o,
  output logic               handled_o,
  output logic               last_o
);
  import pgr_pkg::*;

  cfg_t    cfg;
  push_t   push;
  result_t head;
  logic    room;
  logic    accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  pgr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pgr_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .left_button_i  (left_button_i),
    .right_button_i (right_button_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .cfg_i          (cfg),
    .push_o         (push)
  );

  pgr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // Result fields of the transfer at the head of the queue.
  assign gesture_o = head.gesture;
  assign param_a_o = head.param_a;
  assign param_b_o = head.param_b;
  assign handled_o = head.handled;
  assign last_o    = head.last;

endmodule

>>> sim/tb_pointer_gesture_recognizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pointer_gesture_recognizer_core
// Drives pointer events and time ticks into the gesture recognizer under
// random idling on both sides in most phases. A gesture tracker predicts every result, and
// each result transfer is checked field by field against the oldest result
// still expected. A directed opening covers taps, long taps, drags,
// rotate-zoom and their combinations. Random phases then run under several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------

module tb_pointer_gesture_recognizer_core;
  import pgr_pkg::*;

  localparam int QuietLimit  = 200;
  localparam int RandomItems = 1500;
  localparam int PhaseCount  = 8;
  localparam int MaxPrinted  = 40;

  // One input item as offered to the block.
  typedef struct {
    logic               op;
    logic               left;
    logic               right;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]         ms;
  } pointer_item_t;

  // Tracks the gesture state of the block and holds the results still due.
  class gesture_tracker;
    logic [11:0]        drag_thr;
    logic [13:0]        long_ms;
    logic [14:0]        jump_lim;
    bit                 pressed;
    bit                 dragging;
    bit                 rotating;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] drag_x;
    logic signed [15:0] drag_y;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic [13:0]        held_ms;
    result_t            expected_gestures[$];
    int                 errors;
    int                 results_seen;
    int                 gesture_hits[5];

    function new();
      drag_thr = DragThresholdReset;
      long_ms  = LongPressMsReset;
      jump_lim = RotateJumpLimitReset;
      pressed  = 1'b0;
      dragging = 1'b0;
      rotating = 1'b0;
      origin_x = '0;
      origin_y = '0;
      drag_x   = '0;
      drag_y   = '0;
      rot_x    = '0;
      rot_y    = '0;
      held_ms  = '0;
      errors   = 0;
      results_seen = 0;
      foreach (gesture_hits[k]) gesture_hits[k] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        CfgDragThreshold:   drag_thr = val[11:0];
        CfgLongPressMs:     long_ms  = val[13:0];
        CfgRotateJumpLimit: jump_lim = val;
        default: ;
      endcase
    endfunction

    function result_t make_result(gesture_e g, int a, int b);
      result_t r;
      r.gesture = g;
      r.param_a = a[16:0];
      r.param_b = b[16:0];
      r.handled = 1'b0;
      r.last    = 1'b0;
      return r;
    endfunction

    // Work out the results of one accepted item and queue them.
    function void note_item(pointer_item_t it);
      result_t outs[$];
      bit      handled;
      bit      taken;
      int      xi;
      int      yi;
      int      dx;
      int      dy;
      int      held_sum;
      longint  ex;
      longint  ey;
      handled = 1'b0;
      taken   = 1'b0;
      xi = it.pos_x;
      yi = it.pos_y;
      if (it.op == OpTick) begin
        // Held time only grows on a plain press; it saturates.
        if (pressed && !dragging && !rotating) begin
          held_sum = int'(held_ms) + int'(it.ms);
          held_ms = (held_sum > int'(HeldMax)) ? HeldMax : held_sum[13:0];
          if (held_ms > long_ms) begin
            outs.push_back(make_result(GestLong, origin_x, origin_y));
            pressed  = 1'b0;
            dragging = 1'b0;
            held_ms  = '0;
          end
        end
      end else begin
        // Left button: press, drag start or move, release.
        if (it.left && !pressed) begin
          origin_x = it.pos_x;
          origin_y = it.pos_y;
          dragging = 1'b0;
          pressed  = 1'b1;
          held_ms  = '0;
        end else if (it.left) begin
          if (!dragging) begin
            ex = longint'(it.pos_x) - longint'(origin_x);
            ey = longint'(it.pos_y) - longint'(origin_y);
            if (ex * ex + ey * ey > longint'(drag_thr) * longint'(drag_thr)) begin
              origin_x = it.pos_x;
              origin_y = it.pos_y;
              drag_x   = it.pos_x;
              drag_y   = it.pos_y;
              dragging = 1'b1;
              taken    = 1'b1;
            end
          end else begin
            outs.push_back(make_result(GestDrag, xi - drag_x, yi - drag_y));
            drag_x = it.pos_x;
            drag_y = it.pos_y;
          end
        end else if (pressed) begin
          if (!dragging) begin
            outs.push_back(make_result(GestTap, xi, yi));
            taken = 1'b1;
          end
          pressed  = 1'b0;
          dragging = 1'b0;
        end
        // Right button: rotate start, rotate move, release.
        if (it.right && !rotating) begin
          rot_x    = it.pos_x;
          rot_y    = it.pos_y;
          rotating = 1'b1;
          handled  = 1'b1;
        end else if (it.right) begin
          dx = xi - rot_x;
          dy = yi - rot_y;
          if ((dx < 0 ? -dx : dx) > int'(jump_lim)) dx = 0;
          outs.push_back(make_result(GestRotate, dx, dy));
          rot_x   = it.pos_x;
          rot_y   = it.pos_y;
          handled = 1'b1;
        end else if (rotating) begin
          rotating = 1'b0;
          handled  = 1'b0;
        end else begin
          handled = taken;
        end
      end
      if (outs.size() == 0) outs.push_back(make_result(GestNone, 0, 0));
      outs[outs.size() - 1].handled = handled;
      outs[outs.size() - 1].last    = 1'b1;
      foreach (outs[k]) expected_gestures.push_back(outs[k]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result transfer with the oldest expected result.
    task check_result(result_t got);
      result_t want;
      if (expected_gestures.size() == 0) begin
        report($sformatf("result with nothing expected: gesture %0d a %0d b %0d",
                         got.gesture, got.param_a, got.param_b));
      end else begin
        want = expected_gestures.pop_front();
        results_seen++;
        gesture_hits[int'(want.gesture)]++;
        if (got.gesture !== want.gesture)
          report($sformatf("gesture %0d, expected %0d", got.gesture, want.gesture));
        if (got.param_a !== want.param_a)
          report($sformatf("param_a %0d, expected %0d (gesture %0d)",
                           got.param_a, want.param_a, want.gesture));
        if (got.param_b !== want.param_b)
          report($sformatf("param_b %0d, expected %0d (gesture %0d)",
                           got.param_b, want.param_b, want.gesture));
        if (got.handled !== want.handled)
          report($sformatf("handled %b, expected %b (gesture %0d)",
                           got.handled, want.handled, want.gesture));
        if (got.last !== want.last)
          report($sformatf("last %b, expected %b (gesture %0d)",
                           got.last, want.last, want.gesture));
      end
    endtask
  endclass

  // Block ports; the inputs are all driven to known values from the start.
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_idx_i      = CfgDragThreshold;
  logic [14:0]        cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               op_i           = OpPointer;
  logic               left_button_i  = 1'b0;
  logic               right_button_i = 1'b0;
  logic signed [15:0] pos_x_i        = '0;
  logic signed [15:0] pos_y_i        = '0;
  logic [9:0]         elapsed_ms_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [2:0]         gesture_o;
  logic signed [16:0] param_a_o;
  logic signed [16:0] param_b_o;
  logic               handled_o;
  logic               last_o;

  gesture_tracker tracker = new();

  bit                 idle_on     = 1'b1;
  int                 stall_cnt   = 0;
  int                 quiet_cycles = 0;
  int                 items_sent  = 0;
  int                 settings_run = 0;
  logic signed [15:0] cur_x       = '0;
  logic signed [15:0] cur_y       = '0;
  bit                 hold_left   = 1'b0;
  bit                 hold_right  = 1'b0;

  pointer_gesture_recognizer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .left_button_i  (left_button_i),
    .right_button_i (right_button_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gesture_o      (gesture_o),
    .param_a_o      (param_a_o),
    .param_b_o      (param_b_o),
    .handled_o      (handled_o),
    .last_o         (last_o)
  );

  // Clock.
  always #6 clk_i = ~clk_i;

  // Result side: after each transfer, stall at random while idling is on.
  always @(posedge clk_i) begin
    int hold;
    if (out_valid_o && !out_stall_i) begin
      hold = idle_on ? $urandom_range(0, 3) : 0;
      stall_cnt   <= hold;
      out_stall_i <= (hold != 0);
    end else if (stall_cnt != 0) begin
      stall_cnt   <= stall_cnt - 1;
      out_stall_i <= (stall_cnt > 1);
    end
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.gesture = gesture_e'(gesture_o);
      got.param_a = param_a_o;
      got.param_b = param_b_o;
      got.handled = handled_o;
      got.last    = last_o;
      tracker.check_result(got);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[%0t] timeout: no transfer for %0d cycles", $time, quiet_cycles);
      $display("** pointer_gesture_recognizer_core: FAILED **");
      $finish;
    end
  end

  function automatic pointer_item_t ptr_item(bit l, bit r, int x, int y);
    pointer_item_t it;
    it.op    = OpPointer;
    it.left  = l;
    it.right = r;
    it.pos_x = x[15:0];
    it.pos_y = y[15:0];
    it.ms    = 10'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic pointer_item_t tick_item(logic [9:0] ms);
    pointer_item_t it;
    it.op    = OpTick;
    it.left  = 1'($urandom_range(0, 1));
    it.right = 1'($urandom_range(0, 1));
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    it.ms    = ms;
    return it;
  endfunction

  // Mostly well-formed button sequences with moves around the current point,
  // plus ticks, stray events and jumps anywhere on the plane.
  function automatic pointer_item_t random_item(int span);
    int pick;
    int step_x;
    int step_y;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return tick_item(($urandom_range(0, 19) == 0) ? 10'd1023 :
                       10'($urandom_range(0, 1000)));
    end
    if (pick < 45) begin
      hold_left = !hold_left;
    end else if (pick < 55) begin
      hold_right = !hold_right;
    end else if (pick < 60) begin
      hold_left  = 1'($urandom_range(0, 1));
      hold_right = 1'($urandom_range(0, 1));
      cur_x = 16'($urandom);
      cur_y = 16'($urandom);
    end else if (pick < 96) begin
      step_x = int'($urandom_range(0, 2 * span)) - span;
      step_y = int'($urandom_range(0, 2 * span)) - span;
      cur_x = 16'(int'(cur_x) + step_x);
      cur_y = 16'(int'(cur_y) + step_y);
    end else begin
      cur_x = 16'($urandom);
      cur_y = 16'($urandom);
    end
    return ptr_item(hold_left, hold_right, cur_x, cur_y);
  endfunction

  // Offer one item, after a random gap while idling is on, and wait for its transfer.
  task automatic send_item(pointer_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= it.op;
    left_button_i  <= it.left;
    right_button_i <= it.right;
    pos_x_i        <= it.pos_x;
    pos_y_i        <= it.pos_y;
    elapsed_ms_i   <= it.ms;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_item(it);
    items_sent++;
  endtask

  // Stop offering items and wait until every expected result has arrived.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.expected_gestures.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive cycles while the block is idle.
  task automatic set_config(logic [11:0] thr, logic [13:0] lms, logic [14:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgDragThreshold;
    cfg_wdata_i <= 15'(thr);
    @(posedge clk_i);
    cfg_idx_i   <= CfgLongPressMs;
    cfg_wdata_i <= 15'(lms);
    @(posedge clk_i);
    cfg_idx_i   <= CfgRotateJumpLimit;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(CfgDragThreshold, 15'(thr));
    tracker.set_reg(CfgLongPressMs, 15'(lms));
    tracker.set_reg(CfgRotateJumpLimit, lim);
    settings_run++;
  endtask

  initial begin
    int          per_phase;
    int          span;
    logic [11:0] thr;
    logic [13:0] lms;
    logic [14:0] lim;
    per_phase = RandomItems / PhaseCount;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with the reset settings.
    send_item(tick_item(10'd500));                  // tick with nothing held
    send_item(ptr_item(1, 0, -32768, 32767));       // press at a corner
    send_item(ptr_item(1, 0, -32762, 32759));       // move exactly at the threshold
    send_item(ptr_item(0, 0, -32761, 32759));       // release gives a tap
    send_item(ptr_item(1, 0, 100, 100));
    send_item(ptr_item(1, 0, 111, 100));            // drag starts
    send_item(ptr_item(1, 0, 32767, -32768));       // drag deltas at full scale
    send_item(ptr_item(1, 0, -32768, 32767));
    send_item(ptr_item(0, 0, 0, 0));                // release after a drag
    send_item(ptr_item(1, 0, 5, 5));
    send_item(tick_item(10'd1000));                 // held time reaches the limit
    send_item(tick_item(10'd1));                    // and passes it: long tap
    send_item(ptr_item(0, 0, 5, 5));                // release after a long tap
    send_item(ptr_item(0, 1, 0, 0));                // rotate starts
    send_item(ptr_item(0, 1, 50, -20));
    send_item(ptr_item(0, 1, -32768, 32767));       // x jump is zeroed
    send_item(tick_item(10'd1023));
    send_item(ptr_item(1, 1, -32768, 32767));       // press while rotating
    send_item(tick_item(10'd1023));                 // no held time while rotating
    send_item(ptr_item(0, 1, -32700, 32767));       // tap followed by rotate
    send_item(ptr_item(1, 1, -32700, 32767));
    send_item(ptr_item(1, 1, -32600, 32767));       // drag start under rotate
    send_item(ptr_item(1, 1, -32590, 32760));       // drag followed by rotate
    send_item(ptr_item(0, 0, -32590, 32760));       // both released
    send_item(ptr_item(0, 0, 0, 0));
    settle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin
          thr = 12'd0;
          lms = 14'd1;
          lim = 15'd0;
        end
        1: begin
          thr = 12'd4095;
          lms = 14'd16383;
          lim = 15'd32767;
        end
        2: begin
          thr = DragThresholdReset;
          lms = LongPressMsReset;
          lim = RotateJumpLimitReset;
        end
        3: begin
          thr = 12'd20;
          lms = 14'd0;
          lim = 15'd32767;
        end
        default: begin
          thr = 12'($urandom_range(0, 80));
          lms = 14'($urandom_range(1, 4000));
          lim = 15'($urandom_range(0, 300));
        end
      endcase
      idle_on = (ph != 1) && (ph != 5);
      set_config(thr, lms, lim);
      span = int'(thr) + int'(thr) / 2 + 4;
      hold_left  = 1'b0;
      hold_right = 1'b0;
      repeat (per_phase) send_item(random_item(span));
      settle();
    end

    repeat (4) @(posedge clk_i);
    $display("Sent %0d items under %0d register settings; checked %0d results.",
             items_sent, settings_run + 1, tracker.results_seen);
    $display("Results by kind: none %0d, tap %0d, long tap %0d, drag %0d, rotate %0d.",
             tracker.gesture_hits[0], tracker.gesture_hits[1], tracker.gesture_hits[2],
             tracker.gesture_hits[3], tracker.gesture_hits[4]);
    if (tracker.errors == 0) begin
      $display("** pointer_gesture_recognizer_core: PASSED **");
    end else begin
      $display("** pointer_gesture_recognizer_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> pointer_gesture_recognizer_core.f
+incdir+rtl
rtl/pgr_pkg.sv
rtl/pgr_cfg.sv
rtl/pgr_engine.sv
rtl/pgr_outq.sv
rtl/pointer_gesture_recognizer_core.sv
sim/tb_pointer_gesture_recognizer_core.sv
